>>> rtl/mmlfo_pkg.sv
`timescale 1ns / 1ps

package mmlfo_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SAMPLE_BITS     = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_IDX_BITS   = SINE_TABLE_BITS - 2;
    localparam int SINE_ENTRIES    = 1 << SINE_IDX_BITS;
    localparam int AMP_BITS        = SAMPLE_BITS - 1;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [SAMPLE_BITS-1:0] AMAX = SAMPLE_BITS'((1 << AMP_BITS) - 1);

    localparam longint unsigned PIH_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned Q30_HALF = 64'd1 << 29;
    localparam longint unsigned SINE_Q = 64'd1 << SINE_IDX_BITS;

    typedef enum logic [1:0] {
        MODE_LOW  = 2'd0,
        MODE_HIGH = 2'd1,
        MODE_SINE = 2'd2,
        MODE_TRI  = 2'd3
    } t_mode;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE        = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_PHASE = CFG_INDEX_BITS'(1);

    typedef logic [SINE_ENTRIES-1:0][AMP_BITS-1:0] t_sine_rom;

    // Quarter-wave sine amplitude for table point j, 7-term Taylor series in Q30
    function automatic logic [AMP_BITS-1:0] f_sine_amp(input int j);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned amp;
        x    = (PIH_Q30 * longint'(j)) / SINE_Q;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(Q30_ONE)) begin
            sum = longint'(Q30_ONE);
        end
        amp = (longint'(sum) * longint'(AMAX) + Q30_HALF) >> 30;
        return AMP_BITS'(amp);
    endfunction

    function automatic t_sine_rom f_build_sine_rom();
        t_sine_rom rom;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            rom[k] = f_sine_amp(k);
        end
        return rom;
    endfunction

    localparam t_sine_rom            SINE_ROM  = f_build_sine_rom();
    localparam logic [AMP_BITS-1:0] SINE_PEAK = f_sine_amp(SINE_ENTRIES);

endpackage

>>> rtl/multi_mode_lfo.sv
`timescale 1ns / 1ps

// Multi-mode LFO: each input item (two bounds and a signed phase step) yields one
// output sample that lies between the smaller and the larger bound. Modes 0/1
// output the low/high bound and hold the phase; mode 2 (sine, quarter-wave ROM)
// and mode 3 (exact triangle) map a bipolar wave onto the bound range and then
// advance the 32-bit phase accumulator by the step. A new item is taken every
// cycle unless the output is stalled; each sample passes through four register
// stages: ordering and phase capture, wave amplitude (ROM or one multiply),
// range scaling multiply, and the constant divide by 65534 with the final add.
// Writing start_phase loads the phase accumulator at once.
module multi_mode_lfo (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [mmlfo_pkg::SAMPLE_BITS-1:0] i_low_bound,
    input  logic signed [mmlfo_pkg::SAMPLE_BITS-1:0] i_high_bound,
    input  logic signed [mmlfo_pkg::PHASE_BITS-1:0]  i_phase_step,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [mmlfo_pkg::SAMPLE_BITS-1:0] o_sample,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [mmlfo_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [mmlfo_pkg::PHASE_BITS-1:0]        i_cfg_data
);

    localparam int SB = mmlfo_pkg::SAMPLE_BITS;
    localparam int PB = mmlfo_pkg::PHASE_BITS;
    localparam int IB = mmlfo_pkg::SINE_IDX_BITS;
    localparam int AB = mmlfo_pkg::AMP_BITS;

    mmlfo_pkg::t_mode r_mode;
    logic [PB-1:0]    r_acc;
    logic [PB-1:0]    n_acc;

    logic w_in_accept;
    logic w_cfg_write;
    logic w_cfg_acc;
    logic w_rdy2, w_rdy3, w_rdy4;

    // stage 1
    logic                 r_v1;
    logic signed [SB-1:0] r_s1_lo;
    logic [SB-1:0]        r_s1_range;
    logic [PB-1:0]        r_s1_phase;
    logic                 r_s1_sine;
    // stage 2
    logic                 r_v2;
    logic signed [SB-1:0] r_s2_lo;
    logic [SB-1:0]        r_s2_range;
    logic [SB-1:0]        r_s2_u;
    // stage 3
    logic                 r_v3;
    logic signed [SB-1:0] r_s3_lo;
    logic [2*SB-1:0]      r_s3_num;
    // stage 4
    logic                 r_v4;
    logic signed [SB-1:0] r_s4_sample;

    // stage 1 logic
    logic signed [SB-1:0] w_lo, w_hi;
    logic [SB:0]          w_diff;
    logic signed [SB-1:0] n_s1_lo;
    logic [SB-1:0]        n_s1_range;

    // stage 2 logic
    logic [1:0]      w_quad;
    logic [IB-1:0]   w_sidx;
    logic [AB-1:0]   w_sine_amp;
    logic [PB-2:0]   w_tri_r;
    logic [PB-1:0]   w_tri_mag;
    logic [PB+AB-1:0] w_tri_prod;
    logic [AB-1:0]   w_tri_amp;
    logic [AB-1:0]   w_amp;
    logic [SB-1:0]   n_s2_u;

    // stage 4 logic
    logic [2*SB-2:0] w_half;
    logic [SB-1:0]   w_t;
    logic [SB:0]     w_s;
    logic [1:0]      w_s1;
    logic [SB-1:0]   w_r2;
    logic [SB-1:0]   w_q;
    logic [SB:0]     w_sum;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid & o_cfg_ready;
    assign w_cfg_acc   = w_cfg_write && (i_cfg_index == mmlfo_pkg::CFG_START_PHASE);

    assign w_rdy4      = !r_v4 || i_out_ready;
    assign w_rdy3      = !r_v3 || w_rdy4;
    assign w_rdy2      = !r_v2 || w_rdy3;
    assign o_in_ready  = !r_v1 || w_rdy2;
    assign w_in_accept = i_in_valid & o_in_ready;

    assign o_out_valid = r_v4;
    assign o_sample    = r_s4_sample;

    assign n_acc = r_acc + $unsigned(i_phase_step);

    // bound ordering; constant modes travel as a zero range
    always_comb begin
        w_lo   = (i_low_bound < i_high_bound) ? i_low_bound : i_high_bound;
        w_hi   = (i_low_bound < i_high_bound) ? i_high_bound : i_low_bound;
        w_diff = {w_hi[SB-1], w_hi} - {w_lo[SB-1], w_lo};
        case (r_mode)
            mmlfo_pkg::MODE_LOW: begin
                n_s1_lo    = w_lo;
                n_s1_range = '0;
            end
            mmlfo_pkg::MODE_HIGH: begin
                n_s1_lo    = w_hi;
                n_s1_range = '0;
            end
            default: begin
                n_s1_lo    = w_lo;
                n_s1_range = w_diff[SB-1:0];
            end
        endcase
    end

    // wave amplitude and offset-binary wave value
    always_comb begin
        w_quad  = r_s1_phase[PB-1:PB-2];
        w_sidx  = r_s1_phase[PB-3:PB-2-IB];
        if (!w_quad[0]) begin
            w_sine_amp = mmlfo_pkg::SINE_ROM[w_sidx];
        end else if (w_sidx == '0) begin
            w_sine_amp = mmlfo_pkg::SINE_PEAK;
        end else begin
            w_sine_amp = mmlfo_pkg::SINE_ROM[IB'(~w_sidx + 1'b1)];
        end
        w_tri_r    = {1'b0, r_s1_phase[PB-3:0]};
        w_tri_mag  = w_quad[0] ? ((PB'(1) << (PB-2)) - PB'(w_tri_r)) : PB'(w_tri_r);
        w_tri_prod = (PB+AB)'(w_tri_mag) * (PB+AB)'(mmlfo_pkg::AMAX)
                   + ((PB+AB)'(1) << (PB-3));
        w_tri_amp  = w_tri_prod[PB+AB-3:PB-2];
        w_amp      = r_s1_sine ? w_sine_amp : w_tri_amp;
        n_s2_u     = w_quad[1] ? (mmlfo_pkg::AMAX - SB'(w_amp))
                               : (mmlfo_pkg::AMAX + SB'(w_amp));
    end

    // floor(num / 65534) as floor((num >> 1) / 32767), folded twice
    always_comb begin
        w_half = r_s3_num[2*SB-1:1];
        w_t    = w_half[2*SB-2:SB-1];
        w_s    = (SB+1)'(w_t) + (SB+1)'(w_half[SB-2:0]);
        w_s1   = w_s[SB:SB-1];
        w_r2   = SB'(w_s[SB-2:0]) + SB'(w_s1);
        w_q    = w_t + SB'(w_s1) + SB'(w_r2 >= mmlfo_pkg::AMAX);
        w_sum  = {r_s3_lo[SB-1], r_s3_lo} + {1'b0, w_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mmlfo_pkg::MODE_SINE;
            r_acc  <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
        end else begin
            if (w_cfg_write && i_cfg_index == mmlfo_pkg::CFG_MODE) begin
                r_mode <= mmlfo_pkg::t_mode'(i_cfg_data[1:0]);
            end
            if (w_cfg_acc) begin
                r_acc <= i_cfg_data;
            end else if (w_in_accept && (r_mode == mmlfo_pkg::MODE_SINE
                                      || r_mode == mmlfo_pkg::MODE_TRI)) begin
                r_acc <= n_acc;
            end
            if (o_in_ready) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_lo    <= n_s1_lo;
            r_s1_range <= n_s1_range;
            r_s1_phase <= r_acc;
            r_s1_sine  <= (r_mode == mmlfo_pkg::MODE_SINE);
        end
        if (w_rdy2 && r_v1) begin
            r_s2_lo    <= r_s1_lo;
            r_s2_range <= r_s1_range;
            r_s2_u     <= n_s2_u;
        end
        if (w_rdy3 && r_v2) begin
            r_s3_lo  <= r_s2_lo;
            r_s3_num <= (2*SB)'(r_s2_u) * (2*SB)'(r_s2_range) + (2*SB)'(mmlfo_pkg::AMAX);
        end
        if (w_rdy4 && r_v3) begin
            r_s4_sample <= w_sum[SB-1:0];
        end
    end

`ifndef ASSERT_OFF
    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && !w_cfg_acc && (r_mode == mmlfo_pkg::MODE_LOW
                                    || r_mode == mmlfo_pkg::MODE_HIGH))
        |=> $stable(r_acc))
        else $error("phase moved in a constant mode");

    a_acc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && !w_cfg_acc && (r_mode == mmlfo_pkg::MODE_SINE
                                    || r_mode == mmlfo_pkg::MODE_TRI))
        |=> r_acc == $past(n_acc))
        else $error("phase did not advance by the item step");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule

>>> tb/sv/multi_mode_lfo_tb.sv
`timescale 1ns / 1ps

module multi_mode_lfo_tb;
    import mmlfo_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int LATENCY      = 4;
    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_TICKS = 1200;
    localparam int PHASE_TICKS  = 100;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_2 = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_3 = CFG_INDEX_BITS'(3);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [PHASE_BITS-1:0]         phase_t;
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_style_t;

    localparam longint unsigned PI_HALF_Q30    = 64'd1686629713;
    localparam longint unsigned Q30_UNIT       = 64'd1 << 30;
    localparam longint unsigned QUARTER_POINTS = 64'd1 << (SINE_TABLE_BITS - 2);
    localparam longint          FULL_SCALE     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

    localparam sample_t BOUND_MIN    = sample_t'(1 << (SAMPLE_BITS - 1));
    localparam sample_t BOUND_MAX    = ~BOUND_MIN;
    localparam phase_t  STEP_MIN     = phase_t'(1) << (PHASE_BITS - 1);
    localparam phase_t  STEP_MAX     = ~STEP_MIN;
    localparam phase_t  QUARTER_STEP = phase_t'(1) << (PHASE_BITS - 2);
    localparam phase_t  EIGHTH_STEP  = phase_t'(1) << (PHASE_BITS - 3);

    class lfo_scoreboard;
        t_mode   mode;
        phase_t  start_phase;
        phase_t  phase_acc;
        sample_t expected_samples[$];
        int      errors;

        function new();
            mode        = MODE_SINE;
            start_phase = '0;
            phase_acc   = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, phase_t data);
            if (idx == CFG_MODE) begin
                mode = t_mode'(data[1:0]);
            end else if (idx == CFG_START_PHASE) begin
                start_phase = data;
                phase_acc   = data;
            end
        endfunction

        // quarter-wave sine in Q30, Taylor series to the 13th power
        function longint unsigned quarter_sine(longint unsigned j);
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned divisor;
            longint          total;
            x     = (PI_HALF_Q30 * j) / QUARTER_POINTS;
            x2    = (x * x) >> 30;
            term  = x;
            total = longint'(x);
            for (int n = 1; n <= 6; n++) begin
                divisor = longint'((2 * n) * (2 * n + 1));
                term    = ((term * x2) >> 30) / divisor;
                if (n % 2 == 1) begin
                    total -= longint'(term);
                end else begin
                    total += longint'(term);
                end
            end
            if (total < 0) begin
                total = 0;
            end
            if (total > longint'(Q30_UNIT)) begin
                total = longint'(Q30_UNIT);
            end
            return longint'(total);
        endfunction

        function longint level(longint unsigned mag, logic neg);
            longint a;
            a = longint'((mag * longint'(FULL_SCALE) + (Q30_UNIT >> 1)) >> 30);
            return neg ? -a : a;
        endfunction

        function longint wave_at(phase_t ph);
            logic [SINE_TABLE_BITS-1:0] k;
            logic [1:0]                 quad;
            longint unsigned            r;
            longint unsigned            mag;
            if (mode == MODE_SINE) begin
                k    = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
                quad = k[SINE_TABLE_BITS-1 -: 2];
                r    = k[SINE_TABLE_BITS-3:0];
                mag  = quarter_sine(quad[0] ? QUARTER_POINTS - r : r);
            end else begin
                quad = ph[PHASE_BITS-1 -: 2];
                r    = ph[PHASE_BITS-3:0];
                mag  = quad[0] ? (64'd1 << (PHASE_BITS - 2)) - r : r;
                if (PHASE_BITS >= 32) begin
                    mag = mag >> (PHASE_BITS >= 32 ? PHASE_BITS - 32 : 0);
                end else begin
                    mag = mag << (PHASE_BITS < 32 ? 32 - PHASE_BITS : 0);
                end
            end
            return level(mag, quad[1]);
        endfunction

        function void note_tick(sample_t a_in, sample_t b_in, phase_t step);
            longint a;
            longint b;
            longint lo;
            longint hi;
            longint w;
            longint num;
            longint res;
            a  = a_in;
            b  = b_in;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            case (mode)
                MODE_LOW: begin
                    res = lo;
                end
                MODE_HIGH: begin
                    res = hi;
                end
                default: begin
                    w         = wave_at(phase_acc);
                    num       = (w + FULL_SCALE) * (hi - lo) + FULL_SCALE;
                    res       = lo + num / (2 * FULL_SCALE);
                    phase_acc = phase_acc + step;
                end
            endcase
            expected_samples.push_back(sample_t'(res));
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        task report_mismatch(string msg);
            if (errors < 50) begin
                $display("ERROR at %0t: %s", $time, msg);
            end
            errors++;
        endtask

        task check_sample(sample_t got);
            sample_t want;
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("sample %0d with none expected", got));
            end else begin
                want = expected_samples.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("sample %0d, expected %0d", got, want));
                end
            end
        endtask
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      o_in_ready;
    sample_t                   low_bound  = '0;
    sample_t                   high_bound = '0;
    phase_t                    phase_step = '0;
    logic                      o_out_valid;
    logic                      out_ready = 1'b0;
    sample_t                   o_sample;
    logic                      cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    phase_t                    cfg_data  = '0;

    lfo_scoreboard sb = new();
    rx_style_t     rx_style = RX_FREE;
    int            rx_hold = 0;
    int            idle_cycles = 0;

    multi_mode_lfo dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_low_bound  (low_bound),
        .i_high_bound (high_bound),
        .i_phase_step (phase_step),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_sample     (o_sample),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // result side: check, then pick the next ready level and how long to hold it
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            sb.check_sample(o_sample);
        end
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            case (rx_style)
                RX_FREE: begin
                    out_ready <= 1'b1;
                    rx_hold   <= 4;
                end
                RX_LIGHT: begin
                    out_ready <= ($urandom_range(0, 3) != 0);
                    rx_hold   <= $urandom_range(0, 3);
                end
                default: begin
                    out_ready <= $urandom_range(0, 1);
                    rx_hold   <= $urandom_range(0, 24);
                end
            endcase
        end
    end

    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_tick(input sample_t a, input sample_t b, input phase_t step);
        in_valid   <= 1'b1;
        low_bound  <= a;
        high_bound <= b;
        phase_step <= step;
        @(posedge clk);
        while (!o_in_ready) begin
            @(posedge clk);
        end
        sb.note_tick(a, b, step);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // block must be idle before any register write
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input phase_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!o_cfg_ready) begin
            @(posedge clk);
        end
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input t_mode m, input bit load_phase, input phase_t start,
                             input bit spare);
        phase_t mode_word;
        mode_word      = phase_t'($urandom);
        mode_word[1:0] = m;
        write_reg(CFG_MODE, mode_word);
        if (load_phase) begin
            write_reg(CFG_START_PHASE, start);
        end
        if (spare) begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, phase_t'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic sample_t pick_bound();
        case ($urandom_range(0, 7))
            0: return BOUND_MIN;
            1: return BOUND_MAX;
            2: return '0;
            3: return sample_t'($urandom_range(0, 16)) - sample_t'(8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic phase_t pick_step();
        phase_t small_step;
        small_step = phase_t'($urandom_range(1, 1 << 20));
        case ($urandom_range(0, 9))
            0: return STEP_MAX;
            1: return STEP_MIN;
            2: return '0;
            3: return $urandom_range(0, 1) ? phase_t'(1) : '1;
            4: return $urandom_range(0, 1) ? small_step : -small_step;
            5: return phase_t'($urandom_range(0, (1 << SINE_TABLE_BITS) - 1))
                      << (PHASE_BITS - SINE_TABLE_BITS);
            default: return phase_t'($urandom);
        endcase
    endfunction

    function automatic t_mode pick_mode();
        case ($urandom_range(0, 9))
            0: return MODE_LOW;
            1: return MODE_HIGH;
            2, 3, 4, 5: return MODE_SINE;
            default: return MODE_TRI;
        endcase
    endfunction

    initial begin
        phase_t start;
        int     sent;
        int     burst;
        bit     gappy;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: sine from phase zero, one full cycle in quarter steps
        repeat (5) send_tick(BOUND_MIN, BOUND_MAX, QUARTER_STEP);
        send_tick(BOUND_MAX, BOUND_MIN, -EIGHTH_STEP);
        send_tick('0, '0, STEP_MAX);
        send_tick(BOUND_MIN, BOUND_MIN, STEP_MIN);
        send_tick(sample_t'(-5), sample_t'(123), phase_t'(1));

        settle();
        configure(MODE_TRI, 1'b1, QUARTER_STEP, 1'b1);
        repeat (4) send_tick(BOUND_MIN, BOUND_MAX, EIGHTH_STEP);
        send_tick(BOUND_MAX, BOUND_MIN, STEP_MIN);
        send_tick(sample_t'(-1), '0, '1);
        send_tick(BOUND_MAX, BOUND_MAX, '0);

        settle();
        configure(MODE_LOW, 1'b1, '1, 1'b1);
        send_tick(BOUND_MAX, BOUND_MIN, STEP_MAX);
        send_tick(sample_t'(-7), sample_t'(9), phase_t'(1));

        settle();
        configure(MODE_HIGH, 1'b0, '0, 1'b0);
        send_tick(BOUND_MAX, BOUND_MIN, phase_t'(1));
        send_tick(BOUND_MIN, sample_t'(-1), '1);

        // phase was held at all ones by the constant modes; step across the wrap
        settle();
        configure(MODE_SINE, 1'b0, '0, 1'b0);
        send_tick(BOUND_MIN, BOUND_MAX, phase_t'(1));
        send_tick(BOUND_MIN, BOUND_MAX, STEP_MIN);

        for (int p = 0; p < RANDOM_TICKS / PHASE_TICKS; p++) begin
            settle();
            case ($urandom_range(0, 3))
                0: start = '0;
                1: start = '1;
                default: start = phase_t'($urandom);
            endcase
            configure(pick_mode(), $urandom_range(0, 4) != 0, start, $urandom_range(0, 3) == 0);
            rx_style = rx_style_t'($urandom_range(0, 2));
            gappy    = ($urandom_range(0, 3) != 0);
            sent     = 0;
            while (sent < PHASE_TICKS) begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && sent < PHASE_TICKS; b++) begin
                    send_tick(pick_bound(), pick_bound(), pick_step());
                    sent++;
                end
                if (gappy) begin
                    pause_sender($urandom_range(0, 8));
                end
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (LATENCY * 4) @(posedge clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
